// File: sv/cbu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbu_pkg
// Types and codes shared by the chunked blob upload receiver and its parts.
// ----------------------------------------------------------------------------
package cbu_pkg;

  // Frame kinds carried with every input transaction.
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;
  localparam logic [1:0] KIND_POLL   = 2'd3;

  // Status codes returned at the end of each frame.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FAIL       = 3'd1;
  localparam logic [2:0] ST_CHARGING   = 3'd2;
  localparam logic [2:0] ST_NO_STORAGE = 3'd3;
  localparam logic [2:0] ST_ACK        = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_CHARGING = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  // Minimum frame lengths and header layout.
  localparam logic [15:0] MIN_START_LEN  = 16'd14;
  localparam logic [15:0] MIN_DATA_LEN   = 16'd6;
  localparam logic [15:0] MIN_FINISH_LEN = 16'd4;
  localparam logic [15:0] SEQ_BYTES      = 16'd2;
  localparam logic [15:0] SIZE_FIRST_POS = 16'd9;
  localparam logic [15:0] SIZE_LAST_POS  = 16'd12;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;

  // Capacity and store addresses are carried at this width.
  localparam int CAP_W = 25;

  // Per-frame capture state, as it stands after the current byte.
  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] seq;
    logic [31:0] head_word;
    logic [31:0] head_size;
    logic [31:0] tail;
    logic [31:0] chunk_sum;
  } frame_t;

  // State of the upload that spans frames.
  typedef struct packed {
    logic        active;
    logic [31:0] expected;
    logic [16:0] received;
    logic [15:0] wanted;
    logic [31:0] stored_sum;
  } upload_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] ack_number;
  } result_t;

endpackage

// File: sv/cbu_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbu_judge
// Judges a completed frame against the upload state and gives the status
// together with the upload state that follows the frame.
// ----------------------------------------------------------------------------
module cbu_judge (
  input  logic [1:0]                 kind,
  input  cbu_pkg::frame_t            frame,
  input  cbu_pkg::upload_t           cur,
  input  logic                       charging,
  input  logic [cbu_pkg::CAP_W-1:0]  cap,
  output cbu_pkg::upload_t           nxt,
  output cbu_pkg::result_t           res
);
  import cbu_pkg::*;

  logic [31:0] data_sum;
  logic [17:0] total;

  // The sum of everything before the trailing checksum is the two sequence
  // bytes plus every chunk byte that has left the tail window.
  assign data_sum = frame.chunk_sum + {24'd0, frame.seq[15:8]} + {24'd0, frame.seq[7:0]};
  assign total    = {1'b0, cur.received} + {2'd0, frame.pos - MIN_DATA_LEN};

  always_comb begin
    nxt            = cur;
    res.status     = ST_FAIL;
    res.ack_number = 16'd0;
    unique case (kind)
      KIND_START: begin
        if (frame.pos < MIN_START_LEN) begin
          res.status = ST_FAIL;
        end else if (charging) begin
          res.status = ST_CHARGING;
        end else begin
          // The declared size is kept even when the start is refused.
          nxt.expected = frame.head_size;
          if (frame.head_size == 32'd0 ||
              frame.head_size > {{(32-CAP_W){1'b0}}, cap}) begin
            res.status = ST_NO_STORAGE;
          end else begin
            nxt.active     = 1'b1;
            nxt.received   = 17'd0;
            nxt.stored_sum = 32'd0;
            nxt.wanted     = 16'd1;
            res.status     = ST_ACK;
          end
        end
      end
      KIND_DATA: begin
        if (cur.active && frame.pos >= MIN_DATA_LEN) begin
          if (data_sum != frame.tail || frame.seq != cur.wanted) begin
            nxt.active = 1'b0;
          end else if ({14'd0, total} > cur.expected) begin
            nxt.active = 1'b0;
          end else begin
            nxt.received   = total[17] ? 17'h1FFFF : total[16:0];
            nxt.stored_sum = cur.stored_sum + frame.chunk_sum;
            nxt.wanted     = (cur.wanted == 16'hFFFF) ? cur.wanted : cur.wanted + 16'd1;
            res.status     = ST_ACK;
            res.ack_number = frame.seq;
          end
        end
      end
      KIND_FINISH: begin
        if (cur.active && frame.pos >= MIN_FINISH_LEN) begin
          nxt.active = 1'b0;
          if (frame.head_word == cur.stored_sum &&
              {15'd0, cur.received} == cur.expected) begin
            res.status = ST_OK;
          end
        end
      end
      KIND_POLL: begin
        if (cur.active) begin
          res.status     = ST_ACK;
          res.ack_number = cur.wanted - 16'd1;
        end else begin
          res.status = ST_OK;
        end
      end
      default: begin
        res.status = ST_FAIL;
      end
    endcase
  end

endmodule

// File: sv/cbu_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbu_outbuf
// Result register with a skid stage, so that input transactions keep flowing
// while a finished result waits to be taken.
// ----------------------------------------------------------------------------
module cbu_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cbu_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output cbu_pkg::result_t out_data
);
  import cbu_pkg::*;

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    drain;

  assign drain     = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control: the skid stage fills only when the result register is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (drain) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !drain) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (drain) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload follows the same choices and needs no reset.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (drain) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !drain) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

  // A full skid stage must hold off new results.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && skid_valid_r))
    else $error("result pushed while skid stage full");

  // The skid stage is never occupied with the result register empty.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds data ahead of result register");

  // The skid stage fills only because the result register was stalled.
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid stage filled without a stalled result");

endmodule

// File: sv/chunked_blob_upload_receiver.sv
`timescale 1ns / 1ps
// A frame's result is registered in the result register, or in the skid stage while
//   the result register is held, when the transaction that ends its frame is accepted.
// Throughput: one input transaction per cycle unless in_stall holds the input; all
//   per-byte and end-of-frame work sits between the state registers and the result register.
// Reset (synchronous, rst_n low) clears all upload and frame state and the
//   result stages; the blob store holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// chunked_blob_upload_receiver
// Receives start, data, finish and poll frames byte by byte, writes accepted
// chunk bytes to the blob store and reports one status per frame.
// ----------------------------------------------------------------------------
module chunked_blob_upload_receiver #(
  parameter int STORE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_has_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_ack_number
);
  import cbu_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [CAP_W-1:0] STORE_LIMIT = CAP_W'(STORE_BYTES);

  logic             charging_r;
  logic [16:0]      capacity_r;
  frame_t           frame_r, frame_nxt, frame_byte;
  upload_t          upload_r, upload_nxt, upload_judged;
  result_t          res, out_res;
  logic             in_acc;
  logic             take;
  logic             buf_full;
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] store_addr;
  logic             store_we;
  logic [7:0]       store_data;
  logic [7:0]       blob_store [STORE_BYTES];

  assign in_stall = buf_full;
  assign in_acc   = in_valid && !buf_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charging_r <= 1'b0;
      capacity_r <= 17'h10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHARGING: charging_r <= cfg_data[0];
        CFG_CAPACITY: capacity_r <= cfg_data;
        default:      charging_r <= charging_r;
      endcase
    end
  end

  // The usable capacity is the smaller of the register and the store size.
  assign cap = ({{(CAP_W-17){1'b0}}, capacity_r} > STORE_LIMIT) ?
               STORE_LIMIT : {{(CAP_W-17){1'b0}}, capacity_r};

  // Per-byte update; the position saturates and freezes the frame state.
  assign take       = in_has_byte && (frame_r.pos != POS_MAX);
  assign store_data = frame_r.tail[31:24];
  assign store_addr = {{(CAP_W-17){1'b0}}, upload_r.received} +
                      {{(CAP_W-16){1'b0}}, frame_r.pos - MIN_DATA_LEN};

  always_comb begin
    frame_byte = frame_r;
    store_we   = 1'b0;
    if (take) begin
      if (frame_r.pos >= MIN_DATA_LEN) begin
        // The byte leaving the tail window is chunk data.
        frame_byte.chunk_sum = frame_r.chunk_sum + {24'd0, frame_r.tail[31:24]};
        store_we = in_acc && (in_kind == KIND_DATA) && upload_r.active &&
                   (store_addr < STORE_LIMIT);
      end
      if (frame_r.pos < SEQ_BYTES) begin
        frame_byte.seq = {frame_r.seq[7:0], in_payload_byte};
      end
      if (frame_r.pos < MIN_FINISH_LEN) begin
        frame_byte.head_word = {frame_r.head_word[23:0], in_payload_byte};
      end
      if (frame_r.pos >= SIZE_FIRST_POS && frame_r.pos <= SIZE_LAST_POS) begin
        frame_byte.head_size = {frame_r.head_size[23:0], in_payload_byte};
      end
      frame_byte.tail = {frame_r.tail[23:0], in_payload_byte};
      frame_byte.pos  = frame_r.pos + 16'd1;
    end
  end

  cbu_judge u_judge (
    .kind     (in_kind),
    .frame    (frame_byte),
    .cur      (upload_r),
    .charging (charging_r),
    .cap      (cap),
    .nxt      (upload_judged),
    .res      (res)
  );

  // A frame end judges the frame and starts the next one from clear.
  always_comb begin
    frame_nxt  = frame_r;
    upload_nxt = upload_r;
    if (in_acc) begin
      if (in_frame_end) begin
        frame_nxt  = '0;
        upload_nxt = upload_judged;
      end else begin
        frame_nxt = frame_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= '0;
      upload_r <= '0;
    end else begin
      frame_r  <= frame_nxt;
      upload_r <= upload_nxt;
    end
  end

  // Blob store, written four bytes behind the input.
  always_ff @(posedge clk) begin
    if (store_we) begin
      blob_store[store_addr[AW-1:0]] <= store_data;
    end
  end

  cbu_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && in_frame_end),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_status     = out_res.status;
  assign out_ack_number = out_res.ack_number;

endmodule

// File: tb/sv/tb_chunked_blob_upload_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunked_blob_upload_receiver
// Drives start, data, finish and poll frames into the upload receiver and
// predicts the status of each frame. Every status is checked field by field.
// Directed frames cover the edge cases. Random uploads follow, mostly
// well-formed and some deliberately broken, over several register settings
// and idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_chunked_blob_upload_receiver;
  import cbu_pkg::*;

  localparam int STORE_LIMIT     = 65536;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_REPORTS     = 40;

  // Header layout beyond the sequence and size fields.
  localparam logic [15:0] HEAD_WORD_BYTES = 16'd4;
  localparam logic [15:0] TYPE_POS        = 16'd4;
  localparam logic [15:0] FLAGS_POS       = 16'd5;

  // Predicts the status of each frame and keeps the statuses still owed.
  class frame_status_board;
    bit          charging;
    bit [16:0]   capacity = 17'h10000;
    // Upload state that spans frames.
    bit          active;
    bit [31:0]   expected_bytes, received_bytes, stored_sum, accepted_sum, ident;
    bit [15:0]   wanted;
    bit [7:0]    up_type, up_flags;
    // Capture state of the frame in progress.
    bit [15:0]   pos, seq;
    bit [31:0]   tail, fsum, csum, hword, hsize;
    bit [7:0]    htype, hflags;
    result_t     pending_statuses[$];
    int          mismatches, checked, items;
    int          per_status[5];

    // Absorb one accepted input transaction; a frame end yields a status.
    function void note_item(logic [1:0] kind, logic [7:0] b, logic has, logic fe);
      result_t   r;
      bit [31:0] tsum, total, cap, clen;
      items++;
      if (has && pos != POS_MAX) begin
        // Bytes leaving the four-byte window belong to the chunk.
        if (pos >= MIN_DATA_LEN) csum += tail[31:24];
        if (pos < SEQ_BYTES) seq = {seq[7:0], b};
        if (pos < HEAD_WORD_BYTES) hword = {hword[23:0], b};
        if (pos == TYPE_POS) htype = b;
        if (pos == FLAGS_POS) hflags = b;
        if (pos >= SIZE_FIRST_POS && pos <= SIZE_LAST_POS) hsize = {hsize[23:0], b};
        tail = {tail[23:0], b};
        fsum += b;
        pos++;
      end
      if (!fe) return;

      r.status     = ST_FAIL;
      r.ack_number = '0;
      case (kind)
        KIND_START: begin
          cap = (capacity > STORE_LIMIT) ? STORE_LIMIT : capacity;
          if (pos < MIN_START_LEN) begin
            r.status = ST_FAIL;
          end else if (charging) begin
            r.status = ST_CHARGING;
          end else begin
            // A start refused for its size still updates the header fields.
            ident          = hword;
            up_type        = htype;
            up_flags       = hflags;
            expected_bytes = hsize;
            if (hsize == 0 || hsize > cap) begin
              r.status = ST_NO_STORAGE;
            end else begin
              active         = 1'b1;
              received_bytes = '0;
              stored_sum     = '0;
              wanted         = 16'd1;
              r.status       = ST_ACK;
            end
          end
        end
        KIND_DATA: begin
          if (active && pos >= MIN_DATA_LEN) begin
            tsum  = tail[7:0] + tail[15:8] + tail[23:16] + tail[31:24];
            clen  = pos - MIN_DATA_LEN;
            total = received_bytes + clen;
            if (fsum - tsum != tail || seq != wanted || total > expected_bytes) begin
              active = 1'b0;
            end else begin
              received_bytes = (total > 32'h1FFFF) ? 32'h1FFFF : total;
              stored_sum    += csum;
              if (wanted != 16'hFFFF) wanted++;
              r.status       = ST_ACK;
              r.ack_number   = seq;
            end
          end
        end
        KIND_FINISH: begin
          if (active && pos >= MIN_FINISH_LEN) begin
            if (hword == stored_sum && received_bytes == expected_bytes) begin
              accepted_sum = stored_sum;
              r.status     = ST_OK;
            end
            active = 1'b0;
          end
        end
        KIND_POLL: begin
          if (active) begin
            r.status     = ST_ACK;
            r.ack_number = wanted - 16'd1;
          end else begin
            r.status = ST_OK;
          end
        end
      endcase
      pending_statuses.push_back(r);

      pos    = '0;
      seq    = '0;
      tail   = '0;
      fsum   = '0;
      csum   = '0;
      hword  = '0;
      hsize  = '0;
      htype  = '0;
      hflags = '0;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $time, what);
    endtask

    // Compare one accepted result transaction with the oldest prediction.
    task check_status(logic [2:0] status, logic [15:0] ack);
      result_t want;
      if (pending_statuses.size() == 0) begin
        report($sformatf("status %0d ack %0d arrived with nothing expected", status, ack));
        return;
      end
      want = pending_statuses.pop_front();
      checked++;
      if (status !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d", checked, status,
                         want.status));
      if (ack !== want.ack_number)
        report($sformatf("result %0d: ack_number %0d, expected %0d", checked, ack,
                         want.ack_number));
      if (want.status <= ST_ACK) per_status[want.status]++;
    endtask
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_we          = 1'b0;
  logic        cfg_index       = CFG_CHARGING;
  logic [16:0] cfg_data        = '0;
  logic        in_valid        = 1'b0;
  logic [1:0]  in_kind         = KIND_START;
  logic [7:0]  in_payload_byte = '0;
  logic        in_has_byte     = 1'b0;
  logic        in_frame_end    = 1'b0;
  logic        out_stall       = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_ack_number;

  frame_status_board sb;
  bit [7:0]          frame_bytes[$];
  int                items_sent     = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                pressure_asked = 0;
  int                pressure_seen  = 0;
  int                hold_left      = 0;
  int                quiet_cycles   = 0;

  chunked_blob_upload_receiver #(
    .STORE_BYTES(STORE_LIMIT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_payload_byte(in_payload_byte),
    .in_has_byte    (in_has_byte),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_ack_number (out_ack_number)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result side: check each accepted transaction, then choose the next stall.
  // A pressure request holds the stall for a long stretch.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_status(out_status, out_ack_number);
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_seen != pressure_asked) begin
      pressure_seen <= pressure_asked;
      hold_left     <= HOLD_CYCLES;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one input transaction, with random idle cycles first.
  task automatic send_item(logic [1:0] kind, logic [7:0] b, logic has, logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_payload_byte <= b;
    in_has_byte     <= has;
    in_frame_end    <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(kind, b, has, fe);
    if (has || fe) items_sent++;
  endtask

  // Send the bytes in frame_bytes as one frame. A noisy frame may carry empty
  // items, stray kinds before its last byte, and an end on an empty item.
  task automatic send_frame(logic [1:0] kind, bit noisy);
    int last;
    bit late_end;
    last     = frame_bytes.size() - 1;
    late_end = (last < 0) || (noisy && $urandom_range(14) == 0);
    foreach (frame_bytes[i]) begin
      if (noisy && $urandom_range(19) == 0)
        send_item(2'($urandom), 8'($urandom), 1'b0, 1'b0);
      send_item((noisy && i != last && $urandom_range(29) == 0) ? 2'($urandom) : kind,
                frame_bytes[i], 1'b1, (i == last) && !late_end);
    end
    if (late_end) send_item(kind, 8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic void put_word(bit [31:0] w);
    frame_bytes.push_back(w[31:24]);
    frame_bytes.push_back(w[23:16]);
    frame_bytes.push_back(w[15:8]);
    frame_bytes.push_back(w[7:0]);
  endfunction

  function automatic void put_random(int n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endfunction

  // Start frame: random identity, type, flags and padding, then the size and trailing bytes.
  function automatic void build_start(bit [31:0] size, int extra);
    frame_bytes.delete();
    put_random(SIZE_FIRST_POS);
    put_word(size);
    put_random(1 + extra);
  endfunction

  // Append the byte sum of the frame so far, optionally with one bit flipped.
  function automatic void seal_data(bit corrupt);
    bit [31:0] s = '0;
    foreach (frame_bytes[i]) s += frame_bytes[i];
    if (corrupt) s ^= 32'h1 << $urandom_range(31);
    put_word(s);
  endfunction

  function automatic void build_data(bit [15:0] seq, int clen, bit corrupt);
    frame_bytes.delete();
    frame_bytes.push_back(seq[15:8]);
    frame_bytes.push_back(seq[7:0]);
    put_random(clen);
    seal_data(corrupt);
  endfunction

  function automatic void build_finish(bit [31:0] sum, int extra);
    frame_bytes.delete();
    put_word(sum);
    put_random(extra);
  endfunction

  // One random frame, shaped by the predicted upload state so that most
  // uploads run to completion and a minority break in one way or another.
  task automatic random_frame();
    int        r, cap, left, lim, clen;
    bit [31:0] sum;
    r   = $urandom_range(99);
    cap = (sb.capacity > STORE_LIMIT) ? STORE_LIMIT : int'(sb.capacity);
    if (sb.expected_bytes > sb.received_bytes) begin
      left = (sb.expected_bytes - sb.received_bytes > 600) ? 600 :
             int'(sb.expected_bytes - sb.received_bytes);
    end else begin
      left = 0;
    end

    if (sb.active ? (r >= 90 && r < 95) : (r < 55)) begin
      // Well-formed start; sizes are mostly small.
      lim = (cap < 48) ? cap : 48;
      if ($urandom_range(19) == 0) lim = (cap < 600) ? cap : 600;
      build_start((lim == 0) ? 32'd1 : 32'($urandom_range(1, lim)),
                  ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
      send_frame(KIND_START, 1'b1);
    end else if (sb.active && r < 60) begin
      if (left == 0) begin
        build_finish(sb.stored_sum, ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
        send_frame(KIND_FINISH, 1'b1);
      end else begin
        lim  = ($urandom_range(19) == 0) ? 300 : 16;
        clen = $urandom_range(0, (left < lim) ? left : lim);
        build_data(sb.wanted, clen, 1'b0);
        send_frame(KIND_DATA, 1'b1);
      end
    end else if (sb.active && r < 74) begin
      // Broken chunk: bad sum, wrong sequence or more bytes than declared.
      if (r < 66) begin
        build_data(sb.wanted, $urandom_range(0, 8), 1'b1);
      end else if (r < 70) begin
        build_data(sb.wanted ^ (16'h1 << $urandom_range(15)), $urandom_range(0, 8), 1'b0);
      end else begin
        build_data(sb.wanted, left + $urandom_range(1, 3), 1'b0);
      end
      send_frame(KIND_DATA, 1'b1);
    end else if (sb.active && r < 84) begin
      sum = sb.stored_sum;
      if ($urandom_range(1) == 0) sum ^= 32'h1 << $urandom_range(31);
      build_finish(sum, ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
      send_frame(KIND_FINISH, 1'b1);
    end else if (sb.active ? (r < 90) : (r < 70)) begin
      frame_bytes.delete();
      put_random($urandom_range(0, 2));
      send_frame(KIND_POLL, 1'b1);
    end else if (!sb.active && r < 80) begin
      // Start refused for its size: zero or beyond the capacity.
      if (r < 73) begin
        build_start(32'd0, 0);
      end else if (r < 77) begin
        build_start(32'(cap + $urandom_range(1, 3)), 0);
      end else begin
        build_start(32'($urandom) | 32'h0002_0000, 0);
      end
      send_frame(KIND_START, 1'b1);
    end else begin
      // Junk: any kind, often too short for it.
      frame_bytes.delete();
      put_random($urandom_range(0, 15));
      send_frame(2'($urandom), 1'b1);
    end
  endtask

  // Wait until every predicted status has arrived, then let the block settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_statuses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(bit charging, bit [16:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHARGING;
    cfg_data  <= 17'(charging);
    @(posedge clk);
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.charging = charging;
    sb.capacity = cap;
  endtask

  task automatic run_phase(bit charging, bit [16:0] cap, int send_pct, int stall_pct,
                           int n_items, bit squeeze);
    int target;
    bit squeezed;
    settle();
    write_config(charging, cap);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    target         = items_sent + n_items;
    squeezed       = 1'b0;
    while (items_sent < target) begin
      // Hold the result side off while the sender keeps offering.
      if (squeeze && !squeezed && items_sent > target - n_items / 2) begin
        pressure_asked <= pressure_asked + 1;
        squeezed = 1'b1;
      end
      random_frame();
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // No upload active: poll, stray data and finish, short start.
    frame_bytes.delete();
    send_frame(KIND_POLL, 1'b0);
    build_data(16'd1, 2, 1'b0);
    send_frame(KIND_DATA, 1'b0);
    build_finish(32'd0, 0);
    send_frame(KIND_FINISH, 1'b0);
    build_start(32'd8, 0);
    void'(frame_bytes.pop_back());
    send_frame(KIND_START, 1'b0);

    // Starts refused for a zero size and for a size beyond the store.
    build_start(32'd0, 0);
    send_frame(KIND_START, 1'b0);
    build_start(32'hFFFF_FFFF, 0);
    send_frame(KIND_START, 1'b0);

    // An upload of eight bytes with a short data and a short finish inside.
    build_start(32'd8, 2);
    send_frame(KIND_START, 1'b0);
    frame_bytes.delete();
    send_frame(KIND_POLL, 1'b0);
    build_data(16'd1, 0, 1'b0);
    void'(frame_bytes.pop_back());
    send_frame(KIND_DATA, 1'b0);
    // Extreme byte values, a stray kind and an empty item mid-frame.
    frame_bytes = '{8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF};
    seal_data(1'b0);
    foreach (frame_bytes[i]) begin
      if (i == 3) send_item(KIND_POLL, 8'hA5, 1'b0, 1'b0);
      send_item((i == 2) ? KIND_FINISH : KIND_DATA, frame_bytes[i], 1'b1,
                i == frame_bytes.size() - 1);
    end
    frame_bytes.delete();
    send_frame(KIND_POLL, 1'b0);
    build_finish(sb.stored_sum, 0);
    void'(frame_bytes.pop_back());
    send_frame(KIND_FINISH, 1'b0);
    build_data(16'd2, 5, 1'b0);
    send_frame(KIND_DATA, 1'b0);
    build_finish(sb.stored_sum, 0);
    send_frame(KIND_FINISH, 1'b0);

    // Uploads broken by a bad sum, a wrong sequence, an overrun, a wrong blob
    // sum and a short total.
    build_start(32'd4, 0);
    send_frame(KIND_START, 1'b0);
    build_data(16'd1, 4, 1'b1);
    send_frame(KIND_DATA, 1'b0);
    frame_bytes.delete();
    send_frame(KIND_POLL, 1'b0);
    build_start(32'd4, 0);
    send_frame(KIND_START, 1'b0);
    build_data(16'd2, 1, 1'b0);
    send_frame(KIND_DATA, 1'b0);
    build_start(32'd2, 0);
    send_frame(KIND_START, 1'b0);
    build_data(16'd1, 3, 1'b0);
    send_frame(KIND_DATA, 1'b0);
    build_start(32'd3, 0);
    send_frame(KIND_START, 1'b0);
    build_data(16'd1, 3, 1'b0);
    send_frame(KIND_DATA, 1'b0);
    build_finish(~sb.stored_sum, 0);
    send_frame(KIND_FINISH, 1'b0);
    build_start(32'd3, 0);
    send_frame(KIND_START, 1'b0);
    build_data(16'd1, 2, 1'b0);
    send_frame(KIND_DATA, 1'b0);
    build_finish(sb.stored_sum, 1);
    send_frame(KIND_FINISH, 1'b0);

    // Random uploads over several register settings and flow patterns.
    run_phase(1'b0, 17'h1FFFF, 0, 0, 450, 1'b0);
    run_phase(1'b0, 17'd100, 54, 0, 350, 1'b0);
    run_phase(1'b1, 17'h10000, 26, 26, 150, 1'b0);
    run_phase(1'b0, 17'd0, 0, 0, 100, 1'b0);
    run_phase(1'b0, 17'd1, 0, 54, 100, 1'b0);
    run_phase(1'b0, 17'hFFFF, 0, 54, 300, 1'b0);
    run_phase(1'b0, 17'h10000, 26, 26, 300, 1'b1);

    settle();
    $display("Run covered %0d input transactions and %0d frame statuses", sb.items,
             sb.checked);
    $display("(%0d ok, %0d failed, %0d charging, %0d no storage, %0d acknowledged).",
             sb.per_status[ST_OK], sb.per_status[ST_FAIL], sb.per_status[ST_CHARGING],
             sb.per_status[ST_NO_STORAGE], sb.per_status[ST_ACK]);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
